>>> rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the sparse polynomial adder.
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int MAX_TERMS = 16;
   localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int TERM_W    = 32;

   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] coef_in;
      logic [15:0]        expo_in;
   } req_type;

   typedef struct packed {
      logic signed [16:0] coef_out;
      logic [15:0]        expo_out;
      logic               last;
      logic               overflow;
      logic               empty_res;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] coef;
      logic [15:0]        expo;
   } term_type;

endpackage

>>> rtl/spa_ram.sv
// ----------------------------------------------------------------------------
// spa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> rtl/sparse_polynomial_adder.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_adder
// Loads two descending-exponent term lists into RAMs and merges them on a
// start beat, emitting one summed or copied term per result beat.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  req     | req_valid, req_stall, req_data | cmd, coef_in, expo_in
//  rsp     | rsp_valid, rsp_stall, rsp_data | coef_out, expo_out, last,
//          |                                | overflow, empty_res
//
//  Load beats give no result.
//  A start beat runs the merge: one term per cycle into the output register,
//  paced by the RAM read loop (next index drives the read address).
//  req_stall is high for the whole merge; rsp_stall holds the output register
//  and pauses the merge. Reset is synchronous and clears counts and flags;
//  RAM contents are not cleared.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder
   import spa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic             dropped_ff, dropped_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             req_acc, out_free, emit;
   logic             wr_a, wr_b, a_ok, b_ok, take_a, take_b;
   term_type         wr_term, q_a, q_b;
   logic signed [16:0] coef_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff == ST_MERGE) && out_free;

   assign wr_term.coef = req_data.coef_in;
   assign wr_term.expo = req_data.expo_in;
   assign wr_a = req_acc && (req_data.cmd == CMD_LOAD_A) && (cnt_a_ff < CNT_W'(MAX_TERMS));
   assign wr_b = req_acc && (req_data.cmd == CMD_LOAD_B) && (cnt_b_ff < CNT_W'(MAX_TERMS));

   spa_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[IDX_W-1:0]),
      .wr_data (wr_term),
      .rd_addr (i_in[IDX_W-1:0]),
      .rd_data (q_a)
   );

   spa_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[IDX_W-1:0]),
      .wr_data (wr_term),
      .rd_addr (j_in[IDX_W-1:0]),
      .rd_data (q_b)
   );

   assign a_ok     = i_ff < cnt_a_ff;
   assign b_ok     = j_ff < cnt_b_ff;
   assign coef_sum = {q_a.coef[15], q_a.coef} + {q_b.coef[15], q_b.coef};

   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      if (a_ok && b_ok) begin
         if (q_a.expo == q_b.expo) begin
            take_a = 1'b1;
            take_b = 1'b1;
         end else if (q_a.expo > q_b.expo) begin
            take_a = 1'b1;
         end else begin
            take_b = 1'b1;
         end
      end else begin
         take_a = a_ok;
         take_b = b_ok;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_data.cmd)
                  CMD_LOAD_A: begin
                     if (wr_a) cnt_a_in = cnt_a_ff + CNT_W'(1);
                     else      dropped_in = 1'b1;
                  end
                  CMD_LOAD_B: begin
                     if (wr_b) cnt_b_in = cnt_b_ff + CNT_W'(1);
                     else      dropped_in = 1'b1;
                  end
                  CMD_START: state_in = ST_MERGE;
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            if (emit) begin
               if (take_a) i_in = i_ff + CNT_W'(1);
               if (take_b) j_in = j_ff + CNT_W'(1);
               rsp_valid_in       = 1'b1;
               rsp_in.overflow    = dropped_ff;
               rsp_in.empty_res   = !a_ok && !b_ok;
               rsp_in.last        = (i_in == cnt_a_ff) && (j_in == cnt_b_ff);
               if (take_a && take_b) begin
                  rsp_in.coef_out = coef_sum;
                  rsp_in.expo_out = q_a.expo;
               end else if (take_a) begin
                  rsp_in.coef_out = {q_a.coef[15], q_a.coef};
                  rsp_in.expo_out = q_a.expo;
               end else if (take_b) begin
                  rsp_in.coef_out = {q_b.coef[15], q_b.coef};
                  rsp_in.expo_out = q_b.expo;
               end else begin
                  rsp_in.coef_out = '0;
                  rsp_in.expo_out = '0;
               end
               if (rsp_in.last) begin
                  state_in   = ST_IDLE;
                  cnt_a_in   = '0;
                  cnt_b_in   = '0;
                  i_in       = '0;
                  j_in       = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CNT_W'(MAX_TERMS)) && (cnt_b_ff <= CNT_W'(MAX_TERMS)))
      else $error("term count beyond capacity");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (i_ff <= cnt_a_ff) && (j_ff <= cnt_b_ff))
      else $error("merge index past count");

   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (i_ff == '0) && (j_ff == '0))
      else $error("merge index not cleared in idle");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      emit && rsp_in.last |=> (state_ff == ST_IDLE) && (cnt_a_ff == '0) &&
                              (cnt_b_ff == '0) && !dropped_ff)
      else $error("state not cleared after last beat");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.empty_res |-> rsp_ff.last && (rsp_ff.coef_out == '0) &&
                                           (rsp_ff.expo_out == '0))
      else $error("empty result beat malformed");
`endif

endmodule

>>> tb/spa_checker.sv
// ----------------------------------------------------------------------------
// spa_checker
// Watches both channels of the sparse polynomial adder. Keeps its own copy
// of the two term stores and, on every start beat, merges them into the
// list of terms the block must emit. Compares each result beat against the
// oldest predicted term.
// ----------------------------------------------------------------------------
module spa_checker
   import spa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   term_type first_terms  [MAX_TERMS];
   term_type second_terms [MAX_TERMS];
   int       first_len;
   int       second_len;
   logic     lost_load;
   rsp_type  sum_terms [$];

   function automatic rsp_type sum_term(logic signed [16:0] coef, logic [15:0] expo);
      rsp_type t;
      t.coef_out  = coef;
      t.expo_out  = expo;
      t.last      = 1'b0;
      t.overflow  = lost_load;
      t.empty_res = 1'b0;
      return t;
   endfunction

   always @(posedge clock) begin : track
      int                 i;
      int                 j;
      rsp_type            want;
      logic signed [16:0] coef_sum;
      if (reset) begin
         first_len  = 0;
         second_len = 0;
         lost_load  = 1'b0;
         mismatches = 0;
         sum_terms.delete();
      end else begin
         if (req_valid && !req_stall) begin
            case (req_data.cmd)
               CMD_LOAD_A: begin
                  if (first_len < MAX_TERMS) begin
                     first_terms[first_len] = '{req_data.coef_in, req_data.expo_in};
                     first_len++;
                  end else begin
                     lost_load = 1'b1;
                  end
               end
               CMD_LOAD_B: begin
                  if (second_len < MAX_TERMS) begin
                     second_terms[second_len] = '{req_data.coef_in, req_data.expo_in};
                     second_len++;
                  end else begin
                     lost_load = 1'b1;
                  end
               end
               CMD_START: begin
                  if (first_len == 0 && second_len == 0) begin
                     want = sum_term(17'sd0, 16'd0);
                     want.empty_res = 1'b1;
                     sum_terms.push_back(want);
                  end else begin
                     i = 0;
                     j = 0;
                     while (i < first_len || j < second_len) begin
                        if (i < first_len && j < second_len &&
                            first_terms[i].expo == second_terms[j].expo) begin
                           coef_sum = first_terms[i].coef + second_terms[j].coef;
                           sum_terms.push_back(sum_term(coef_sum, first_terms[i].expo));
                           i++;
                           j++;
                        end else if (j >= second_len || (i < first_len &&
                                     first_terms[i].expo > second_terms[j].expo)) begin
                           sum_terms.push_back(sum_term(first_terms[i].coef,
                                                        first_terms[i].expo));
                           i++;
                        end else begin
                           sum_terms.push_back(sum_term(second_terms[j].coef,
                                                        second_terms[j].expo));
                           j++;
                        end
                     end
                  end
                  sum_terms[sum_terms.size() - 1].last = 1'b1;
                  first_len  = 0;
                  second_len = 0;
                  lost_load  = 1'b0;
               end
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (sum_terms.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: coef=%0d expo=%0d last=%0b ovf=%0b empty=%0b",
                           rsp_data.coef_out, rsp_data.expo_out, rsp_data.last,
                           rsp_data.overflow, rsp_data.empty_res);
            end else begin
               want = sum_terms.pop_front();
               if (rsp_data.coef_out !== want.coef_out || rsp_data.expo_out !== want.expo_out ||
                   rsp_data.last !== want.last || rsp_data.overflow !== want.overflow ||
                   rsp_data.empty_res !== want.empty_res) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result mismatch: expected coef=%0d expo=%0d last=%0b ovf=%0b ",
                               "empty=%0b, got coef=%0d expo=%0d last=%0b ovf=%0b empty=%0b"},
                              want.coef_out, want.expo_out, want.last, want.overflow,
                              want.empty_res, rsp_data.coef_out, rsp_data.expo_out,
                              rsp_data.last, rsp_data.overflow, rsp_data.empty_res);
               end
            end
         end
      end
      pending <= sum_terms.size();
   end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the sparse polynomial adder. A directed part
// covers empty merges, the unused command, coefficient extremes,
// cancellation and unordered lists; a random part then loads term lists of
// random size (some past capacity), interleaved with noise, and merges them
// under bursty input and random output back-pressure.
// ----------------------------------------------------------------------------
module testbench
   import spa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         ITEM_TARGET    = 370;
   localparam int         CYCLE_LIMIT    = 200000;
   localparam int         DRAIN_CYCLES   = 40;
   localparam int         HOLDOFF_CYCLES = 400;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      pending;
   int      cycle_count = 0;
   int      items_sent  = 0;
   int      burst_left  = 0;
   bit      holdoff_req = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sparse_polynomial_adder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   spa_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic req_type make_beat(int cmd, int coef, int expo);
      req_type beat;
      beat.cmd     = 2'(cmd);
      beat.coef_in = 16'(coef);
      beat.expo_in = 16'(expo);
      return beat;
   endfunction

   task automatic send_beat(req_type beat);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (beat.cmd != CMD_UNUSED) items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // output back-pressure: random segments, plus one long hold-off on request
   initial begin : receiver
      int mode;
      @(posedge clock);
      forever begin
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(4, 50)) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      req_type first_q  [$];
      req_type second_q [$];
      int      style;
      int      first_goal;
      int      second_goal;
      int      pick;
      int      coef;
      int      expo;
      bit      holdoff_done;
      holdoff_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty merges, unused command in between
      send_beat(make_beat(CMD_START, 1234, 77));
      send_beat(make_beat(CMD_UNUSED, -1, 65535));
      send_beat(make_beat(CMD_START, 0, 0));
      drain_results();

      // sums at both ends of the result range
      send_beat(make_beat(CMD_LOAD_A, 32767, 65535));
      send_beat(make_beat(CMD_LOAD_B, 32767, 65535));
      send_beat(make_beat(CMD_LOAD_A, -32768, 0));
      send_beat(make_beat(CMD_LOAD_B, -32768, 0));
      send_beat(make_beat(CMD_START, -1, 65535));

      // cancellation, unequal heads, first list out of order
      send_beat(make_beat(CMD_LOAD_A, 5, 300));
      send_beat(make_beat(CMD_LOAD_B, -5, 300));
      send_beat(make_beat(CMD_LOAD_A, 9, 100));
      send_beat(make_beat(CMD_LOAD_A, -3, 250));
      send_beat(make_beat(CMD_LOAD_B, 7, 200));
      send_beat(make_beat(CMD_LOAD_B, 1, 0));
      send_beat(make_beat(CMD_START, 0, 0));

      // one list only, each side
      send_beat(make_beat(CMD_LOAD_B, -2, 40));
      send_beat(make_beat(CMD_LOAD_B, 6, 39));
      send_beat(make_beat(CMD_START, 0, 0));
      send_beat(make_beat(CMD_LOAD_A, 32767, 1));
      send_beat(make_beat(CMD_START, 0, 0));

      while (items_sent < ITEM_TARGET) begin
         if (!holdoff_done && items_sent >= 120) begin
            holdoff_req  = 1'b1;
            holdoff_done = 1'b1;
         end
         style = $urandom_range(0, 19);
         first_q.delete();
         second_q.delete();
         if (style == 0) begin
            // loose beats of any command
            repeat ($urandom_range(1, 6))
               send_beat(make_beat($urandom_range(0, 3), $urandom, $urandom));
         end else begin
            first_goal  = $urandom_range(0, 16);
            second_goal = $urandom_range(0, 16);
            if (style == 1) first_goal = $urandom_range(17, 20);
            if (style == 2) second_goal = $urandom_range(17, 20);
            if (style == 5) begin
               first_goal  = 0;
               second_goal = 0;
            end
            expo = (style == 3) ? 65535 : $urandom_range(0, 65535);
            while (first_q.size() < first_goal || second_q.size() < second_goal) begin
               pick = $urandom_range(0, 2);
               if (first_q.size() >= first_goal) pick = 1;
               else if (second_q.size() >= second_goal) pick = 0;
               coef = $urandom;
               if (style == 4) expo = $urandom_range(0, 65535);
               if (pick != 1) first_q.push_back(make_beat(CMD_LOAD_A, coef, expo));
               if (pick != 0)
                  second_q.push_back(make_beat(CMD_LOAD_B,
                     (pick == 2 && $urandom_range(0, 3) == 0) ? -coef : $urandom, expo));
               // descending walk; a wrap below zero leaves the list out of order
               expo = expo - $urandom_range(1, 3);
            end
            while (first_q.size() + second_q.size() > 0) begin
               if (second_q.size() == 0 || (first_q.size() > 0 && $urandom_range(0, 1)))
                  send_beat(first_q.pop_front());
               else
                  send_beat(second_q.pop_front());
               if ($urandom_range(0, 15) == 0)
                  send_beat(make_beat(CMD_UNUSED, $urandom, $urandom));
            end
            send_beat(make_beat(CMD_START, $urandom, $urandom));
            if ($urandom_range(0, 5) == 0) drain_results();
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/sparse_polynomial_adder.sv
tb/spa_checker.sv
tb/testbench.sv
